FILE: design/ssf_pkg.sv
`timescale 1ns / 1ps

package ssf_pkg;

	// register select codes
	localparam logic [2:0] REG_CONFIG    = 3'd0;
	localparam logic [2:0] REG_DECODE    = 3'd1;
	localparam logic [2:0] REG_INTENSITY = 3'd2;
	localparam logic [2:0] REG_SCAN      = 3'd3;
	localparam logic [2:0] REG_POINT     = 3'd4;
	localparam logic [2:0] REG_DATA      = 3'd5;

	localparam logic [2:0] BYTES_ONE  = 3'd1;
	localparam logic [2:0] BYTES_WORD = 3'd4;

	localparam logic [7:0] CFG_ON        = 8'h21;
	localparam logic [7:0] CFG_OFF       = 8'h20;
	localparam logic [7:0] DECODE_NONE   = 8'h00;
	localparam logic [7:0] LEVEL_DEFAULT = 8'd16;
	localparam logic [7:0] NIBBLE_LO     = 8'h0F;
	localparam logic [7:0] NIBBLE_HI     = 8'hF0;
	localparam logic [3:0] DIGITS_MAX    = 4'd8;
	localparam logic [3:0] DIGITS_CHIP   = 4'd4;
	localparam logic [7:0] SCAN_FULL     = 8'd3;

	// write slots, in emission order
	localparam int         NUM_SLOTS   = 14;
	localparam logic [3:0] SLOT_INT_LO = 4'd8;
	localparam logic [3:0] SLOT_INT_HI = 4'd9;
	localparam logic [3:0] SLOT_PT_LO  = 4'd10;
	localparam logic [3:0] SLOT_PT_HI  = 4'd11;
	localparam logic [3:0] SLOT_SEG_LO = 4'd12;
	localparam logic [3:0] SLOT_SEG_HI = 4'd13;

	typedef logic [NUM_SLOTS-1:0] ssf_mask_t;

	typedef struct packed {
		ssf_mask_t   mask;
		logic [3:0]  digits;
		logic [7:0]  bfull;
		logic [7:0]  bhalf;
		logic [7:0]  points;
		logic [31:0] seg_lo;
		logic [31:0] seg_hi;
	} ssf_job_t;

	typedef struct packed {
		logic        chip_select;
		logic [2:0]  register_select;
		logic [31:0] write_data;
		logic [2:0]  byte_count;
	} ssf_write_t;

	// Build the register write for one slot of a job.
	function automatic ssf_write_t ssf_slot_write(input logic [3:0] slot, input ssf_job_t job);
		ssf_write_t w;
		logic       lo;
		logic       hi;
		logic [7:0] lvl;
		logic [7:0] data;
		lo   = (job.digits != 4'd0);
		hi   = (job.digits > DIGITS_CHIP);
		lvl  = hi ? job.bfull : job.bhalf;
		if (lvl == 8'd0) begin
			lvl = LEVEL_DEFAULT;
		end
		data = 8'd0;
		w.chip_select     = 1'b0;
		w.register_select = REG_CONFIG;
		w.byte_count      = BYTES_ONE;
		w.write_data      = 32'd0;
		if (slot < SLOT_INT_LO) begin
			if (!lo) begin
				// both chips off: low chip first
				w.chip_select     = slot[1];
				w.register_select = slot[0] ? REG_SCAN : REG_CONFIG;
				data              = slot[0] ? 8'd0 : CFG_OFF;
			end else if (!hi) begin
				if (slot < 4'd2) begin
					w.chip_select     = 1'b1;
					w.register_select = slot[0] ? REG_SCAN : REG_CONFIG;
					data              = slot[0] ? 8'd0 : CFG_OFF;
				end else begin
					case (slot)
						4'd2: begin
							w.register_select = REG_CONFIG;
							data              = CFG_ON;
						end
						4'd3: begin
							w.register_select = REG_DECODE;
							data              = DECODE_NONE;
						end
						4'd4: begin
							w.register_select = REG_INTENSITY;
							data              = lvl;
						end
						default: begin
							w.register_select = REG_SCAN;
							data              = {4'd0, job.digits - 4'd1};
						end
					endcase
				end
			end else begin
				w.chip_select = slot[2];
				case (slot[1:0])
					2'd0: begin
						w.register_select = REG_CONFIG;
						data              = CFG_ON;
					end
					2'd1: begin
						w.register_select = REG_DECODE;
						data              = DECODE_NONE;
					end
					2'd2: begin
						w.register_select = REG_INTENSITY;
						data              = lvl;
					end
					default: begin
						w.register_select = REG_SCAN;
						data = slot[2] ? {4'd0, job.digits - 4'd5} : SCAN_FULL;
					end
				endcase
			end
			w.write_data = {24'd0, data};
		end else begin
			case (slot)
				SLOT_INT_LO: begin
					w.register_select = REG_INTENSITY;
					w.write_data      = {24'd0, hi ? job.bfull : job.bhalf};
				end
				SLOT_INT_HI: begin
					w.chip_select     = 1'b1;
					w.register_select = REG_INTENSITY;
					w.write_data      = {24'd0, job.bfull};
				end
				SLOT_PT_LO: begin
					w.register_select = REG_POINT;
					w.write_data      = {24'd0, job.points[3:0], 4'd0};
				end
				SLOT_PT_HI: begin
					w.chip_select     = 1'b1;
					w.register_select = REG_POINT;
					w.write_data      = {24'd0, job.points & NIBBLE_HI};
				end
				SLOT_SEG_LO: begin
					w.register_select = REG_DATA;
					w.write_data      = job.seg_lo;
					w.byte_count      = BYTES_WORD;
				end
				default: begin
					w.chip_select     = 1'b1;
					w.register_select = REG_DATA;
					w.write_data      = job.seg_hi;
					w.byte_count      = BYTES_WORD;
				end
			endcase
		end
		return w;
	endfunction

endpackage

FILE: design/ssf_front.sv
`timescale 1ns / 1ps

module ssf_front import ssf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        display_enable,
	input  logic        accept,
	input  logic [7:0]  digit_count,
	input  logic [7:0]  brightness_full,
	input  logic [7:0]  brightness_half,
	input  logic [7:0]  point_bits,
	input  logic [31:0] segments_low,
	input  logic [31:0] segments_high,
	input  logic        force_write,
	output logic        push,
	output ssf_job_t    job
);

	logic [3:0]  fl_digits_q;
	logic [7:0]  fl_bfull_q;
	logic [7:0]  fl_bhalf_q;
	logic [7:0]  fl_points_q;
	logic [31:0] fl_seg_lo_q;
	logic [31:0] fl_seg_hi_q;

	logic [3:0] digits;
	logic       lo;
	logic       hi;
	logic       forced;
	logic [7:0] pdiff;
	ssf_mask_t  mask;

	always_comb begin
		digits = (digit_count > {4'd0, DIGITS_MAX}) ? DIGITS_MAX : digit_count[3:0];
		lo     = (digits != 4'd0);
		hi     = (digits > DIGITS_CHIP);
		forced = (digits != fl_digits_q) || force_write;
		pdiff  = point_bits ^ fl_points_q;
		mask   = '0;
		if (forced) begin
			mask[7:0] = !lo ? 8'h0F : (!hi ? 8'h3F : 8'hFF);
		end
		if (display_enable) begin
			if (lo && hi && (brightness_full != fl_bfull_q)) begin
				mask[SLOT_INT_LO] = 1'b1;
				mask[SLOT_INT_HI] = 1'b1;
			end else if (lo && !hi && (brightness_half != fl_bhalf_q)) begin
				mask[SLOT_INT_LO] = 1'b1;
			end else if (forced) begin
				mask[SLOT_INT_LO] = 1'b1;
				mask[SLOT_INT_HI] = lo && hi;
			end
			if (pdiff != 8'd0) begin
				mask[SLOT_PT_LO] = lo && ((pdiff & NIBBLE_LO) != 8'd0);
				mask[SLOT_PT_HI] = hi && ((pdiff & NIBBLE_HI) != 8'd0);
			end else if (forced) begin
				mask[SLOT_PT_LO] = lo;
				mask[SLOT_PT_HI] = hi;
			end
			mask[SLOT_SEG_LO] = lo && ((segments_low != fl_seg_lo_q) || forced);
			mask[SLOT_SEG_HI] = hi && ((segments_high != fl_seg_hi_q) || forced);
		end
	end

	assign job.mask   = mask;
	assign job.digits = digits;
	assign job.bfull  = brightness_full;
	assign job.bhalf  = brightness_half;
	assign job.points = point_bits;
	assign job.seg_lo = segments_low;
	assign job.seg_hi = segments_high;

	// drop words that cause no write
	assign push = accept && (mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_digits_q <= '0;
			fl_bfull_q  <= '0;
			fl_bhalf_q  <= '0;
			fl_points_q <= '0;
			fl_seg_lo_q <= '0;
			fl_seg_hi_q <= '0;
		end else if (accept && display_enable) begin
			fl_digits_q <= digits;
			fl_bfull_q  <= brightness_full;
			fl_bhalf_q  <= brightness_half;
			fl_points_q <= point_bits;
			fl_seg_lo_q <= segments_low;
			fl_seg_hi_q <= segments_high;
		end
	end

endmodule

FILE: design/ssf_queue.sv
`timescale 1ns / 1ps

module ssf_queue import ssf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ssf_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output ssf_job_t head_job
);

	ssf_job_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: design/ssf_back.sv
`timescale 1ns / 1ps

module ssf_back import ssf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  ssf_job_t    head_job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        chip_select,
	output logic [2:0]  register_select,
	output logic [31:0] write_data,
	output logic [2:0]  byte_count,
	output logic        last_write
);

	ssf_job_t   job_q;
	ssf_mask_t  mask_q;
	logic       out_valid_q;
	ssf_write_t out_write_q;
	logic       out_last_q;

	logic       emit;
	logic [3:0] slot;
	ssf_mask_t  mask_next;
	ssf_write_t wr;

	// lowest pending slot goes first
	always_comb begin
		slot = 4'd0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				slot = 4'(i);
			end
		end
	end

	assign mask_next = mask_q & (mask_q - ssf_mask_t'(1));
	assign wr        = ssf_slot_write(slot, job_q);
	assign emit      = (mask_q != '0) && (!out_valid_q || !out_stall);
	assign pop       = head_valid && ((mask_q == '0) || (emit && (mask_next == '0)));

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (emit) begin
			out_write_q <= wr;
			out_last_q  <= (mask_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= head_job.mask;
			end else if (emit) begin
				mask_q <= mask_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign chip_select     = out_write_q.chip_select;
	assign register_select = out_write_q.register_select;
	assign write_data      = out_write_q.write_data;
	assign byte_count      = out_write_q.byte_count;
	assign last_write      = out_last_q;

endmodule

FILE: design/seven_segment_frame_flush_sequencer_top.sv
`timescale 1ns / 1ps
// Path: the first register write of a request passes the job queue, the sequencer's
//   job register and the output register; the rest follow one per cycle while out_stall is low.
// Throughput: a request needs 0 to 14 writes, which the write sequencer emits back to back;
//   the front takes one word per cycle while the two-entry job queue has room.
// Reset (arst_n low): flushed frame cleared to zero, display_enable set, queue and
//   output register empty.

module seven_segment_frame_flush_sequencer_top import ssf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  digit_count,
	input  logic [7:0]  brightness_full,
	input  logic [7:0]  brightness_half,
	input  logic [7:0]  point_bits,
	input  logic [31:0] segments_low,
	input  logic [31:0] segments_high,
	input  logic        force_write,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        display_enable,
	// register write channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        chip_select,
	output logic [2:0]  register_select,
	output logic [31:0] write_data,
	output logic [2:0]  byte_count,
	output logic        last_write
);

	logic     enable_q;
	logic     accept;
	logic     push;
	ssf_job_t push_job;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	ssf_job_t head_job;

	// The user must write the configuration register only while the block is
	// idle (the block does not enforce it), so take every write at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= display_enable;
		end
	end

	// Hold the requester only while the job queue is full; a word that
	// needs no write is still taken and only updates the flushed frame while enabled.
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Front: clamp the count, compare with the flushed frame, and build
	// the mask of write slots this request needs.
	ssf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.display_enable  (enable_q),
		.accept          (accept),
		.digit_count     (digit_count),
		.brightness_full (brightness_full),
		.brightness_half (brightness_half),
		.point_bits      (point_bits),
		.segments_low    (segments_low),
		.segments_high   (segments_high),
		.force_write     (force_write),
		.push            (push),
		.job             (push_job)
	);

	// Short queue between classification and sequencing.
	ssf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back: walk the slot mask lowest first, one write per cycle, into an
	// output register that advances whenever it is empty or not stalled.
	ssf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_job        (head_job),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chip_select     (chip_select),
		.register_select (register_select),
		.write_data      (write_data),
		.byte_count      (byte_count),
		.last_write      (last_write)
	);

endmodule
